@@ src/facl_pkg.sv @@
// Shared constants for the fully associative FIFO cache lookup.
package facl_pkg;

  // Input address beat width, fixed by the interface.
  localparam int unsigned AddrInW = 32;

  // Width of the hit and miss counters.
  localparam int unsigned CountW = 32;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

endpackage

@@ src/fully_associative_fifo_cache_lookup.sv @@
// Top level: fully associative tag lookup with FIFO replacement and hit/miss counters.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one address per beat; the
//   low ADDR_WIDTH bits (zero-extended if wider) form the tag.
//   Output channel (out_valid_o / out_ready_i) carries one result beat per
//   input beat: hit flag plus running hit and miss counts, including this access.
//   Tags live in a chain of ENTRIES cells. All cells compare in parallel; on a
//   miss the whole chain shifts by one, the new tag enters cell 0 and the
//   oldest tag drops off the far end, which is FIFO replacement.
//   The result beat comes from a result register loaded when the input beat is taken.
//   Throughput: 1 beat per cycle while out_ready_i is high; the single
//   compare-and-shift step over the cell chain and the counter update act together.
//   Stall: the result register holds while out_ready_i is low; a new input beat
//   is taken in the same cycle the held result is taken, else in_ready_o is low.
//   Reset: all valid bits, both counters and the result valid clear at once;
//   the block takes a beat in the first cycle after reset.
//   Counters saturate at all ones.
module fully_associative_fifo_cache_lookup #(
  parameter int unsigned ENTRIES    = 32,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [facl_pkg::AddrInW-1:0]     address_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [facl_pkg::CountW-1:0]      hit_count_o,
  output logic [facl_pkg::CountW-1:0]      miss_count_o
);

  localparam int unsigned TagW = ADDR_WIDTH;

  logic [TagW-1:0]  lookup_tag;
  logic [TagW-1:0]  chain_tag   [ENTRIES+1];
  logic             chain_valid [ENTRIES+1];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] valid_vec;
  logic             in_accept;
  logic             lookup_hit;
  logic             shift_en;

  logic                         out_valid_q;
  logic                         hit_q;
  logic [facl_pkg::CountW-1:0]  hit_cnt_q, hit_cnt_d;
  logic [facl_pkg::CountW-1:0]  miss_cnt_q, miss_cnt_d;

  if (TagW > facl_pkg::AddrInW) begin : g_tag_ext
    assign lookup_tag = {{(TagW - facl_pkg::AddrInW){1'b0}}, address_i};
  end else if (TagW == facl_pkg::AddrInW) begin : g_tag_eq
    assign lookup_tag = address_i;
  end else begin : g_tag_trunc
    assign lookup_tag = address_i[TagW-1:0];
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;
  assign lookup_hit = |match_vec;
  assign shift_en   = in_accept && !lookup_hit;

  // Head of the chain: the new tag on a miss.
  assign chain_tag[0]   = lookup_tag;
  assign chain_valid[0] = 1'b1;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    facl_cell #(
      .TagW (TagW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (shift_en),
      .tag_i        (chain_tag[i]),
      .valid_i      (chain_valid[i]),
      .lookup_tag_i (lookup_tag),
      .tag_o        (chain_tag[i+1]),
      .valid_o      (chain_valid[i+1]),
      .match_o      (match_vec[i])
    );
    assign valid_vec[i] = chain_valid[i+1];
  end

  always_comb begin
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (in_accept) begin
      if (lookup_hit) begin
        if (hit_cnt_q != facl_pkg::CountMax) begin
          hit_cnt_d = hit_cnt_q + facl_pkg::CountW'(1);
        end
      end else begin
        if (miss_cnt_q != facl_pkg::CountMax) begin
          miss_cnt_d = miss_cnt_q + facl_pkg::CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
    end else begin
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hit_q <= lookup_hit;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign hit_count_o  = hit_cnt_q;
  assign miss_count_o = miss_cnt_q;

  // A miss never inserts a duplicate, so at most one cell matches.
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("more than one cell matched the lookup tag");

  // Valid cells always fill from the head of the chain without gaps.
  a_valid_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + ENTRIES'(1)) & valid_vec) == '0)
    else $error("valid bits not contiguous from the chain head");

  // After a miss the head cell holds the missed tag.
  a_miss_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_en |=> (valid_vec[0] && chain_tag[1] == $past(lookup_tag)))
    else $error("missed tag not inserted at chain head");

  // A hit below saturation bumps the hit count by one and leaves misses alone.
  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && lookup_hit && hit_cnt_q != facl_pkg::CountMax) |=>
      (hit_cnt_q == $past(hit_cnt_q) + facl_pkg::CountW'(1) &&
       miss_cnt_q == $past(miss_cnt_q)))
    else $error("hit counter update wrong");

endmodule

@@ src/facl_cell.sv @@
// One tag cell of the lookup chain: holds a tag and valid bit, compares, shifts.
module facl_cell #(
  parameter int unsigned TagW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic [TagW-1:0] tag_i,
  input  logic            valid_i,
  input  logic [TagW-1:0] lookup_tag_i,
  output logic [TagW-1:0] tag_o,
  output logic            valid_o,
  output logic            match_o
);

  logic [TagW-1:0] tag_q;
  logic            valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  // Tag carries no reset; it is only looked at when valid.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tag_q <= tag_i;
    end
  end

  assign match_o = valid_q && (tag_q == lookup_tag_i);
  assign tag_o   = tag_q;
  assign valid_o = valid_q;

endmodule

@@ tb/tb_top.sv @@
// Testbench for the fully associative FIFO cache lookup: directed table, then mixed random traffic.
module tb_top;

  localparam int unsigned Entries     = 32;
  localparam int unsigned PtrW        = $clog2(Entries);
  localparam int unsigned HotSize     = 40;
  localparam int unsigned RandomBeats = 1700;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned DirRows     = 12;

  typedef logic [facl_pkg::AddrInW-1:0] addr_t;
  typedef logic [facl_pkg::CountW-1:0]  count_t;

  typedef struct packed {
    logic   hit;
    count_t hits;
    count_t misses;
  } lookup_result_t;

  // One row may expand into a run of addresses: base, base+stride, ...
  typedef struct packed {
    addr_t          base;
    addr_t          stride;
    logic [7:0]     reps;
    logic           typed;
    lookup_result_t res;
  } stim_row_t;

  logic   clk        = 1'b0;
  logic   rst_n      = 1'b0;
  logic   in_valid   = 1'b0;
  logic   in_ready;
  addr_t  address    = '0;
  logic   out_valid;
  logic   out_ready  = 1'b0;
  logic   hit;
  count_t hit_count;
  count_t miss_count;

  // Predictor state
  addr_t           tag_copy [Entries];
  logic            tag_valid [Entries] = '{default: 1'b0};
  logic [PtrW-1:0] fill_idx    = '0;
  count_t          hits_seen   = '0;
  count_t          misses_seen = '0;

  lookup_result_t expected_results [$];
  addr_t          hot_set [HotSize];
  int unsigned    errors      = 0;
  int unsigned    cycle_count = 0;

  // Store fills with 0, all ones, two checkerboards, then 28 more; the later rows
  // check hit on a full store and eviction of the oldest entry in fill order.
  stim_row_t dir_rows [DirRows] = '{
    '{32'h0000_0000, 32'h0,  8'd1,  1'b1, '{1'b0, 32'd0, 32'd1}},  // invalid zero tags ignored
    '{32'h0000_0000, 32'h0,  8'd1,  1'b1, '{1'b1, 32'd1, 32'd1}},
    '{32'hFFFF_FFFF, 32'h0,  8'd1,  1'b1, '{1'b0, 32'd1, 32'd2}},
    '{32'hFFFF_FFFF, 32'h0,  8'd1,  1'b1, '{1'b1, 32'd2, 32'd2}},
    '{32'h5555_5555, 32'h0,  8'd1,  1'b1, '{1'b0, 32'd2, 32'd3}},
    '{32'hAAAA_AAAA, 32'h0,  8'd1,  1'b1, '{1'b0, 32'd2, 32'd4}},
    '{32'h0000_1000, 32'h10, 8'd28, 1'b0, '0},                     // fills the store
    '{32'h0000_0000, 32'h0,  8'd1,  1'b1, '{1'b1, 32'd3, 32'd32}},
    '{32'h1234_5678, 32'h0,  8'd1,  1'b1, '{1'b0, 32'd3, 32'd33}}, // evicts 0
    '{32'h0000_0000, 32'h0,  8'd1,  1'b1, '{1'b0, 32'd3, 32'd34}}, // evicts all ones
    '{32'h5555_5555, 32'h0,  8'd1,  1'b1, '{1'b1, 32'd4, 32'd34}},
    '{32'hFFFF_FFFF, 32'h0,  8'd1,  1'b1, '{1'b0, 32'd4, 32'd35}}
  };

  fully_associative_fifo_cache_lookup u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .address_i    (address),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .hit_o        (hit),
    .hit_count_o  (hit_count),
    .miss_count_o (miss_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic lookup_result_t step_cache(input addr_t a);
    lookup_result_t r;
    r.hit = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      if (tag_valid[i] && tag_copy[i] == a) r.hit = 1'b1;
    end
    if (r.hit) begin
      if (hits_seen != facl_pkg::CountMax) hits_seen++;
    end else begin
      if (misses_seen != facl_pkg::CountMax) misses_seen++;
      tag_copy[fill_idx]  = a;
      tag_valid[fill_idx] = 1'b1;
      fill_idx++;
    end
    r.hits   = hits_seen;
    r.misses = misses_seen;
    return r;
  endfunction

  // Mostly resident tags and a working set a bit larger than the store, so
  // hits, thrashing and eviction all show up; then one-bit near misses and noise.
  function automatic addr_t pick_address();
    int unsigned sel;
    int unsigned idx;
    sel = $urandom_range(99);
    idx = $urandom_range(Entries - 1);
    if (sel < 40 && tag_valid[idx]) return tag_copy[idx];
    if (sel < 70) return hot_set[$urandom_range(HotSize - 1)];
    if (sel < 85 && tag_valid[idx]) begin
      return tag_copy[idx] ^ (addr_t'(1) << $urandom_range(facl_pkg::AddrInW - 1));
    end
    return $urandom;
  endfunction

  task automatic send_beat(input addr_t a, input logic typed, input lookup_result_t typed_res);
    lookup_result_t predicted;
    address  <= a;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = step_cache(a);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (hot_set[i]) hot_set[i] = $urandom;

    foreach (dir_rows[r]) begin
      for (int unsigned k = 0; k < dir_rows[r].reps; k++) begin
        send_beat(dir_rows[r].base + k * dir_rows[r].stride, dir_rows[r].typed, dir_rows[r].res);
        maybe_idle();
      end
    end
    drain_results();

    for (int unsigned n = 0; n < RandomBeats; n++) begin
      if (n == 900) drain_results();
      send_beat(pick_address(), 1'b0, '0);
      // back-to-back stretch with no sender gaps
      if (n < 1100 || n >= 1400) maybe_idle();
    end
    drain_results();
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  // Receiver: random stalls, one long hold-off so the block backs up, one quiet stretch.
  initial begin : result_sink
    int unsigned rx_cycle;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle >= 1000 && rx_cycle < 1250) out_ready <= 1'b0;
      else if (rx_cycle >= 1600 && rx_cycle < 2000) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no lookup pending: hit=%0b", hit);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, hit);
          errors++;
        end
        if (hit_count !== want.hits) begin
          $error("hit_count: expected %0d, got %0d", want.hits, hit_count);
          errors++;
        end
        if (miss_count !== want.misses) begin
          $error("miss_count: expected %0d, got %0d", want.misses, miss_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
src/facl_pkg.sv
src/facl_cell.sv
src/fully_associative_fifo_cache_lookup.sv
tb/tb_top.sv
